/* src/mem_pkg.sv */
// Shared types and constants for the motion envelope matcher.
`default_nettype none

package mem_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int AXES        = 3;
    localparam int IDX_BITS    = $clog2(MAX_POINTS);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int STEP_BITS   = TIME_BITS - 1;
    localparam int FAIL_LIMIT  = 2;

    // Interpolation datapath widths.
    localparam int DIFF_BITS  = TIME_BITS + 1;
    localparam int DS_BITS    = SAMPLE_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + DS_BITS;
    localparam int QUO_BITS   = SAMPLE_BITS + 1;
    localparam int ITER_BITS  = $clog2(QUO_BITS);
    localparam int SUM_BITS   = QUO_BITS + 2;

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(100 * 10000);

    localparam logic CFG_STEP_TIME   = 1'b0;
    localparam logic CFG_POINT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_BEGIN  = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_END    = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        TS_IDLE      = 2'd0,
        TS_TESTING   = 2'd1,
        TS_SUCCEEDED = 2'd2,
        TS_FAILED    = 2'd3
    } t_test_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_req_type                     req_type;
        logic [5:0]                    entry_index;
        logic signed [TIME_BITS-1:0]   event_time;
        logic signed [SAMPLE_BITS-1:0] value_x;
        logic signed [SAMPLE_BITS-1:0] value_y;
        logic signed [SAMPLE_BITS-1:0] value_z;
        logic signed [SAMPLE_BITS-1:0] upper_x;
        logic signed [SAMPLE_BITS-1:0] upper_y;
        logic signed [SAMPLE_BITS-1:0] upper_z;
        logic                          completed;
    } t_request;

    typedef struct packed {
        t_test_status  test_status;
        logic          checked;
        logic          passed;
        logic [6:0]    checkpoint_index;
        logic [6:0]    consecutive_fails;
    } t_result;

    typedef struct packed {
        logic [TIME_BITS-1:0]              cp_time;
        logic [AXES-1:0][SAMPLE_BITS-1:0]  lower;
        logic [AXES-1:0][SAMPLE_BITS-1:0]  upper;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

`default_nettype wire

/* src/mem_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module mem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/motion_envelope_matcher_top.sv */
// Top level of the motion envelope matcher: control, interpolation and bound check.
`default_nettype none

// The matcher checks a timestamped three-axis acceleration stream against an
// envelope of up to 64 checkpoints, each holding a time plus lower and upper
// bounds per axis, kept in one 128-bit-wide synchronous RAM. Every accepted
// item returns exactly one result item. Load, begin and end items, and samples
// that do not reach a checkpoint, are first decoded against the envelope entry
// read at acceptance, and the result is then loaded into the output register.
// A sample that lands on the previous sample's time skips the arithmetic and
// goes straight from decoding to the bound check. A sample that interpolates
// goes through the decode and envelope lookup, the three parallel 33x17-bit
// multiplies, the overflow test, the restoring divider (one quotient bit per
// cycle, one divider lane per axis), then the add and saturate, the compare
// and state update, and loading the output register. One item is processed
// at a time; the input is stalled while an item is in flight, but a finished
// result may still wait in the output register while the next item is taken.
// Interpolated values use truncating division and are saturated to 16 bits
// before the bound check. Envelope entries hold no defined value until
// loaded, and a test must not reach a checkpoint that was never loaded.
// Configuration (step time and point count) must be written only while the
// block is idle; the block itself does not enforce this.

module motion_envelope_matcher_top
    import mem_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,

    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_index,
    input  wire logic [STEP_BITS-1:0] i_cfg_data,

    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_request i_in_item,

    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_result       o_out_item
);

    // Control state.
    t_state          r_state, n_state;
    t_test_status    r_status, n_status;
    logic [CNT_BITS-1:0] r_next_cp, n_next_cp;
    logic [CNT_BITS-1:0] r_fail_run, n_fail_run;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic [CNT_BITS-1:0] r_point_count, n_point_count;
    logic            r_out_valid, n_out_valid;

    // Payload and datapath registers.
    t_request        r_req, n_req;
    t_result         r_out, n_out;
    logic            r_checked, n_checked;
    logic            r_passed, n_passed;
    logic [TIME_BITS-1:0] r_prev_time, n_prev_time;
    logic [AXES-1:0][SAMPLE_BITS-1:0] r_prev_s, n_prev_s;
    logic [DIFF_BITS-1:0] r_dnum, n_dnum;
    logic [DIFF_BITS-1:0] r_dden, n_dden;
    logic [DIFF_BITS-1:0] r_dmag, n_dmag;
    logic [AXES-1:0][DS_BITS-1:0] r_dsamp, n_dsamp;
    logic [AXES-1:0][PROD_BITS-1:0] r_rem, n_rem;
    logic [PROD_BITS-1:0] r_dsh, n_dsh;
    logic [AXES-1:0][QUO_BITS-1:0] r_quo, n_quo;
    logic [AXES-1:0] r_qneg, n_qneg;
    logic [AXES-1:0] r_ovf, n_ovf;
    logic [ITER_BITS-1:0] r_iter, n_iter;
    logic [AXES-1:0][SAMPLE_BITS-1:0] r_v, n_v;

    // Envelope RAM.
    logic            ram_we;
    logic            ram_re;
    logic [ENTRY_BITS-1:0] ram_rdata;
    t_entry          wr_entry;
    t_entry          rd_entry;
    logic            in_accept;

    function automatic logic [DIFF_BITS-1:0] f_mag(input logic [DIFF_BITS-1:0] x);
        return x[DIFF_BITS-1] ? DIFF_BITS'(-x) : x;
    endfunction

    function automatic logic [DS_BITS-1:0] f_mag_s(input logic [DS_BITS-1:0] x);
        return x[DS_BITS-1] ? DS_BITS'(-x) : x;
    endfunction

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

    // A load item writes its entry as it is taken; a sample reads the next
    // checkpoint so that the entry is ready in the following cycle.
    assign ram_we = in_accept && (i_in_item.req_type == REQ_LOAD);
    assign ram_re = in_accept && (i_in_item.req_type == REQ_SAMPLE);
    assign rd_entry = t_entry'(ram_rdata);

    always_comb begin
        wr_entry.cp_time  = i_in_item.event_time;
        wr_entry.lower[0] = i_in_item.value_x;
        wr_entry.lower[1] = i_in_item.value_y;
        wr_entry.lower[2] = i_in_item.value_z;
        wr_entry.upper[0] = i_in_item.upper_x;
        wr_entry.upper[1] = i_in_item.upper_y;
        wr_entry.upper[2] = i_in_item.upper_z;
    end

    mem_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_POINTS)
    ) u_envelope_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_item.entry_index[IDX_BITS-1:0]),
        .i_wdata (ENTRY_BITS'(wr_entry)),
        .i_re    (ram_re),
        .i_raddr (r_next_cp[IDX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic [CNT_BITS-1:0] count;
        logic [AXES-1:0][SAMPLE_BITS-1:0] cur;
        logic [DIFF_BITS-1:0] nmag;
        logic [QUO_BITS:0] qs;
        logic [SUM_BITS-1:0] sum;
        logic all_ok;
        logic [CNT_BITS-1:0] fails;

        n_state       = r_state;
        n_status      = r_status;
        n_next_cp     = r_next_cp;
        n_fail_run    = r_fail_run;
        n_step        = r_step;
        n_point_count = r_point_count;
        n_out_valid   = r_out_valid && i_out_stall;
        n_req         = r_req;
        n_out         = r_out;
        n_checked     = r_checked;
        n_passed      = r_passed;
        n_prev_time   = r_prev_time;
        n_prev_s      = r_prev_s;
        n_dnum        = r_dnum;
        n_dden        = r_dden;
        n_dmag        = r_dmag;
        n_dsamp       = r_dsamp;
        n_rem         = r_rem;
        n_dsh         = r_dsh;
        n_quo         = r_quo;
        n_qneg        = r_qneg;
        n_ovf         = r_ovf;
        n_iter        = r_iter;
        n_v           = r_v;

        count = (r_point_count > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS)
                                                         : r_point_count;
        cur[0] = r_req.value_x;
        cur[1] = r_req.value_y;
        cur[2] = r_req.value_z;
        nmag   = f_mag(r_dnum);
        qs     = '0;
        sum    = '0;
        all_ok = 1'b1;
        fails  = r_fail_run + CNT_BITS'(1);

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_STEP_TIME) begin
                n_step = i_cfg_data;
            end else begin
                n_point_count = i_cfg_data[CNT_BITS-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req     = i_in_item;
                    n_checked = 1'b0;
                    n_passed  = 1'b0;
                    n_state   = S_LOOK;
                end
            end

            S_LOOK: begin
                n_state = S_DONE;
                case (r_req.req_type)
                    REQ_BEGIN: begin
                        n_status    = TS_TESTING;
                        n_prev_time = TIME_BITS'(-{1'b0, r_step});
                        n_prev_s    = '0;
                        n_next_cp   = '0;
                        n_fail_run  = '0;
                    end
                    REQ_SAMPLE: begin
                        if (r_status == TS_TESTING && r_next_cp < count) begin
                            if ($signed(r_req.event_time) < $signed(rd_entry.cp_time)) begin
                                // Too early for the checkpoint: just remember it.
                                n_prev_time = r_req.event_time;
                                n_prev_s    = cur;
                            end else if (r_req.event_time == r_prev_time) begin
                                n_v     = cur;
                                n_state = S_CHECK;
                            end else begin
                                n_dnum = DIFF_BITS'($signed(rd_entry.cp_time))
                                       - DIFF_BITS'($signed(r_prev_time));
                                n_dden = DIFF_BITS'($signed(r_req.event_time))
                                       - DIFF_BITS'($signed(r_prev_time));
                                for (int a = 0; a < AXES; a++) begin
                                    n_dsamp[a] = DS_BITS'($signed(cur[a]))
                                               - DS_BITS'($signed(r_prev_s[a]));
                                end
                                n_state = S_MUL;
                            end
                        end
                    end
                    REQ_END: begin
                        if (r_status == TS_TESTING) begin
                            if (!r_req.completed || r_next_cp < count) begin
                                n_status = TS_FAILED;
                            end else begin
                                n_status = TS_SUCCEEDED;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_MUL: begin
                for (int a = 0; a < AXES; a++) begin
                    n_rem[a]  = PROD_BITS'(nmag * f_mag_s(r_dsamp[a]));
                    n_qneg[a] = r_dnum[DIFF_BITS-1] ^ r_dsamp[a][DS_BITS-1]
                              ^ r_dden[DIFF_BITS-1];
                end
                n_dmag  = f_mag(r_dden);
                n_state = S_PREP;
            end

            S_PREP: begin
                // A quotient that does not fit in QUO_BITS saturates anyway.
                for (int a = 0; a < AXES; a++) begin
                    n_ovf[a] = (r_rem[a] >= PROD_BITS'({r_dmag, QUO_BITS'(0)}));
                end
                n_dsh   = PROD_BITS'({r_dmag, (QUO_BITS-1)'(0)});
                n_quo   = '0;
                n_iter  = ITER_BITS'(QUO_BITS - 1);
                n_state = S_DIV;
            end

            S_DIV: begin
                for (int a = 0; a < AXES; a++) begin
                    if (r_rem[a] >= r_dsh) begin
                        n_rem[a] = r_rem[a] - r_dsh;
                        n_quo[a] = {r_quo[a][QUO_BITS-2:0], 1'b1};
                    end else begin
                        n_quo[a] = {r_quo[a][QUO_BITS-2:0], 1'b0};
                    end
                end
                n_dsh = r_dsh >> 1;
                if (r_iter == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_iter = r_iter - ITER_BITS'(1);
                end
            end

            S_FIN: begin
                for (int a = 0; a < AXES; a++) begin
                    qs  = r_qneg[a] ? (QUO_BITS+1)'(-{1'b0, r_quo[a]})
                                    : {1'b0, r_quo[a]};
                    sum = SUM_BITS'($signed(r_prev_s[a])) + SUM_BITS'($signed(qs));
                    if (r_ovf[a]) begin
                        n_v[a] = r_qneg[a] ? {1'b1, (SAMPLE_BITS-1)'(0)}
                                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    end else if ($signed(sum) > $signed(SUM_BITS'({1'b0,
                                 {(SAMPLE_BITS-1){1'b1}}}))) begin
                        n_v[a] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    end else if ($signed(sum) < $signed({{(SUM_BITS-SAMPLE_BITS+1){1'b1}},
                                 (SAMPLE_BITS-1)'(0)})) begin
                        n_v[a] = {1'b1, (SAMPLE_BITS-1)'(0)};
                    end else begin
                        n_v[a] = sum[SAMPLE_BITS-1:0];
                    end
                end
                n_state = S_CHECK;
            end

            S_CHECK: begin
                for (int a = 0; a < AXES; a++) begin
                    if ($signed(r_v[a]) < $signed(rd_entry.lower[a]) ||
                        $signed(rd_entry.upper[a]) < $signed(r_v[a])) begin
                        all_ok = 1'b0;
                    end
                end
                n_checked = 1'b1;
                if (all_ok) begin
                    n_passed   = 1'b1;
                    n_fail_run = '0;
                end else begin
                    n_fail_run = fails;
                    if (fails > CNT_BITS'(FAIL_LIMIT) || fails == count) begin
                        n_status = TS_FAILED;
                    end
                end
                n_prev_time = r_req.event_time;
                n_prev_s    = cur;
                n_next_cp   = r_next_cp + CNT_BITS'(1);
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out.test_status       = r_status;
                    n_out.checked           = r_checked;
                    n_out.passed            = r_passed;
                    n_out.checkpoint_index  = r_next_cp;
                    n_out.consecutive_fails = r_fail_run;
                    n_state                 = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_status      <= TS_IDLE;
            r_next_cp     <= '0;
            r_fail_run    <= '0;
            r_step        <= STEP_RESET;
            r_point_count <= '0;
            r_out_valid   <= 1'b0;
            r_prev_time   <= '0;
            r_prev_s      <= '0;
        end else begin
            r_state       <= n_state;
            r_status      <= n_status;
            r_next_cp     <= n_next_cp;
            r_fail_run    <= n_fail_run;
            r_step        <= n_step;
            r_point_count <= n_point_count;
            r_out_valid   <= n_out_valid;
            r_prev_time   <= n_prev_time;
            r_prev_s      <= n_prev_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_out     <= n_out;
        r_checked <= n_checked;
        r_passed  <= n_passed;
        r_dnum    <= n_dnum;
        r_dden    <= n_dden;
        r_dmag    <= n_dmag;
        r_dsamp   <= n_dsamp;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_quo     <= n_quo;
        r_qneg    <= n_qneg;
        r_ovf     <= n_ovf;
        r_iter    <= n_iter;
        r_v       <= n_v;
    end

`ifndef ASSERT_OFF
    // A result never reports a pass for a checkpoint it did not evaluate.
    a_pass_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.passed && !o_out_item.checked))
        else $error("passed set without checked");

    // The failure run stops as soon as it exceeds the limit.
    a_fail_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_run <= CNT_BITS'(FAIL_LIMIT + 1))
        else $error("failure run beyond limit");

    // The checkpoint pointer only advances by one or restarts at zero.
    a_next_cp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_cp != $past(r_next_cp)) |->
        (r_next_cp == $past(r_next_cp) + CNT_BITS'(1) || r_next_cp == '0))
        else $error("checkpoint pointer jumped");

    // Leaving the divider always leads to the saturating add.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_iter == '0) |=> (r_state == S_FIN))
        else $error("divider exit lost");
`endif

endmodule

`default_nettype wire

/* sim/tb_motion_envelope_matcher_top.sv */
// Self-checking testbench for the motion envelope matcher top level.
`timescale 1ns / 100ps

module tb_motion_envelope_matcher_top
    import mem_pkg::*;
();

    // Upper bound on the whole run; it only catches a hung handshake.
    localparam int CYCLE_LIMIT = 1000000;
    // Cycles the receiver refuses results during the long hold-off.
    localparam int HOLD_CYCLES = 400;
    // Quiet cycles after the last result, well past the longest item latency.
    localparam int TAIL_CYCLES = 40;

    // The scoreboard mirrors the envelope store, the test status and the
    // interpolation state. Each accepted item is run through the same rules
    // as the block, and the resulting status word is queued until the block
    // hands back its own result item.
    class envelope_scoreboard;
        int           cp_time [MAX_POINTS];
        shortint      lo_bound [MAX_POINTS][AXES];
        shortint      up_bound [MAX_POINTS][AXES];
        bit           written [MAX_POINTS];
        t_test_status status;
        int           next_cp;
        int           fail_run;
        int           prev_time;
        shortint      prev_val [AXES];
        logic [STEP_BITS-1:0] step_time;
        logic [6:0]   point_count;
        t_result      outcome_q [$];
        int           mismatch_count;

        function new();
            status         = TS_IDLE;
            next_cp        = 0;
            fail_run       = 0;
            prev_time      = 0;
            step_time      = STEP_RESET;
            point_count    = '0;
            mismatch_count = 0;
            foreach (prev_val[a]) prev_val[a] = 0;
            foreach (written[k]) begin
                written[k] = 1'b0;
                cp_time[k] = 0;
                for (int a = 0; a < AXES; a++) begin
                    lo_bound[k][a] = 0;
                    up_bound[k][a] = 0;
                end
            end
        endfunction

        function int active_count();
            return (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
        endfunction

        function void write_cfg(logic idx, logic [STEP_BITS-1:0] val);
            if (idx == CFG_STEP_TIME) step_time = val;
            else point_count = val[6:0];
        endfunction

        // True when a sample item would make the block read an envelope
        // entry that was never loaded.
        function bit reads_unwritten();
            return status == TS_TESTING && next_cp < active_count() && !written[next_cp];
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_request(t_request rq);
            t_result res;
            longint  cur [AXES];
            longint  num;
            longint  v;
            int      cnt;
            int      t;
            int      ct;
            int      n;
            bit      ok;
            bit      chk;
            bit      pass;

            chk    = 1'b0;
            pass   = 1'b0;
            cnt    = active_count();
            t      = $signed(rq.event_time);
            cur[0] = $signed(rq.value_x);
            cur[1] = $signed(rq.value_y);
            cur[2] = $signed(rq.value_z);

            case (rq.req_type)
                REQ_LOAD: begin
                    n = rq.entry_index;
                    written[n]     = 1'b1;
                    cp_time[n]     = t;
                    lo_bound[n][0] = $signed(rq.value_x);
                    lo_bound[n][1] = $signed(rq.value_y);
                    lo_bound[n][2] = $signed(rq.value_z);
                    up_bound[n][0] = $signed(rq.upper_x);
                    up_bound[n][1] = $signed(rq.upper_y);
                    up_bound[n][2] = $signed(rq.upper_z);
                end
                REQ_BEGIN: begin
                    status    = TS_TESTING;
                    prev_time = -int'({1'b0, step_time});
                    foreach (prev_val[a]) prev_val[a] = 0;
                    next_cp   = 0;
                    fail_run  = 0;
                end
                REQ_SAMPLE: begin
                    if (status == TS_TESTING && next_cp < cnt) begin
                        n  = next_cp;
                        ct = cp_time[n];
                        if (t >= ct) begin
                            ok = 1'b1;
                            for (int a = 0; a < AXES; a++) begin
                                if (t == prev_time) begin
                                    v = cur[a];
                                end else begin
                                    num = (longint'(ct) - longint'(prev_time))
                                          * (cur[a] - longint'(prev_val[a]));
                                    v = longint'(prev_val[a])
                                        + num / (longint'(t) - longint'(prev_time));
                                    if (v > 32767) v = 32767;
                                    if (v < -32768) v = -32768;
                                end
                                if (v < lo_bound[n][a] || v > up_bound[n][a]) ok = 1'b0;
                            end
                            chk = 1'b1;
                            if (ok) begin
                                pass     = 1'b1;
                                fail_run = 0;
                            end else begin
                                fail_run++;
                                if (fail_run > FAIL_LIMIT || fail_run == cnt) status = TS_FAILED;
                            end
                            next_cp = n + 1;
                        end
                        // Whether or not a checkpoint was reached, this sample
                        // becomes the start point of the next interpolation.
                        prev_time = t;
                        foreach (prev_val[a]) prev_val[a] = shortint'(cur[a]);
                    end
                end
                REQ_END: begin
                    if (status == TS_TESTING) begin
                        if (!rq.completed || next_cp < cnt) status = TS_FAILED;
                        else status = TS_SUCCEEDED;
                    end
                end
                default: begin
                end
            endcase

            res.test_status       = status;
            res.checked           = chk;
            res.passed            = pass;
            res.checkpoint_index  = 7'(next_cp);
            res.consecutive_fails = 7'(fail_run);
            outcome_q = {outcome_q, res};
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                mismatch_count++;
            end
        endfunction

        function void check_outcome(t_result got);
            t_result exp_res;
            if (outcome_q.size() == 0) begin
                $display("%0t: result item with none expected, actual %h", $time, got);
                mismatch_count++;
                return;
            end
            exp_res = outcome_q.pop_front();
            compare_field("test_status", exp_res.test_status, got.test_status);
            compare_field("checked", exp_res.checked, got.checked);
            compare_field("passed", exp_res.passed, got.passed);
            compare_field("checkpoint_index", exp_res.checkpoint_index, got.checkpoint_index);
            compare_field("consecutive_fails", exp_res.consecutive_fails,
                          got.consecutive_fails);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [STEP_BITS-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    t_request             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_result              out_item;

    envelope_scoreboard sb = new();

    // Per-cycle idle odds in percent for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;
    int phase_sent;
    int cycle_count = 0;

    motion_envelope_matcher_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a run that never drains ends here as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result monitor. Signals are read right after the edge, so they hold the
    // values the block saw at that edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_outcome(out_item);
    end

    // Receiver: random stalls at the current odds, plus one long hold-off on
    // request so that the block backs up and stalls its input.
    initial begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic t_request rand_item();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(t_request)-1:0];
    endfunction

    // Fields that an item type does not use are left random on purpose.
    function automatic t_request make_load(int idx, int t, int lo, int up);
        t_request it;
        it             = rand_item();
        it.req_type    = REQ_LOAD;
        it.entry_index = 6'(idx);
        it.event_time  = t;
        it.value_x     = 16'(lo);
        it.value_y     = 16'(lo);
        it.value_z     = 16'(lo);
        it.upper_x     = 16'(up);
        it.upper_y     = 16'(up);
        it.upper_z     = 16'(up);
        return it;
    endfunction

    function automatic t_request make_begin();
        t_request it;
        it          = rand_item();
        it.req_type = REQ_BEGIN;
        return it;
    endfunction

    function automatic t_request make_sample(int t, int x, int y, int z);
        t_request it;
        it            = rand_item();
        it.req_type   = REQ_SAMPLE;
        it.event_time = t;
        it.value_x    = 16'(x);
        it.value_y    = 16'(y);
        it.value_z    = 16'(z);
        return it;
    endfunction

    function automatic t_request make_end(bit done);
        t_request it;
        it           = rand_item();
        it.req_type  = REQ_END;
        it.completed = done;
        return it;
    endfunction

    // A load with independent random bounds per axis; now and then the
    // window closes to a single value.
    function automatic t_request random_load(int idx, int t);
        t_request it;
        int lo [AXES];
        int up [AXES];
        it = make_load(idx, t, 0, 0);
        for (int a = 0; a < AXES; a++) begin
            lo[a] = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(7) == 0) up[a] = lo[a];
            else up[a] = lo[a] + int'($urandom_range(0, 40000));
            if (up[a] > 32767) up[a] = 32767;
        end
        it.value_x = 16'(lo[0]);
        it.value_y = 16'(lo[1]);
        it.value_z = 16'(lo[2]);
        it.upper_x = 16'(up[0]);
        it.upper_y = 16'(up[1]);
        it.upper_z = 16'(up[2]);
        return it;
    endfunction

    // A sample aimed at the next checkpoint: before it, on it, past it, on
    // the previous sample's time, or anywhere. Values mostly sit inside the
    // target window so that passes and failures both come up.
    function automatic t_request random_sample(int spacing);
        int n;
        int ct;
        int t;
        int v [AXES];
        int lo;
        int up;
        n  = (sb.next_cp < MAX_POINTS) ? sb.next_cp : MAX_POINTS - 1;
        ct = sb.cp_time[n];
        case ($urandom_range(9))
            0, 1, 2, 3: t = ct - int'($urandom_range(1, spacing));
            4, 5:       t = ct;
            6, 7:       t = ct + int'($urandom_range(1, spacing));
            8:          t = sb.prev_time;
            default:    t = int'($urandom);
        endcase
        for (int a = 0; a < AXES; a++) begin
            lo = sb.lo_bound[n][a];
            up = sb.up_bound[n][a];
            if ($urandom_range(3) != 0 && up >= lo) v[a] = lo + int'($urandom_range(0, up - lo));
            else v[a] = int'($urandom_range(0, 65535)) - 32768;
        end
        return make_sample(t, v[0], v[1], v[2]);
    endfunction

    // Offers one item and returns at the edge where it is taken. Valid stays
    // high between back-to-back items. A sample that would reach an entry
    // never loaded is turned into a load of that entry instead.
    task automatic send(input t_request it);
        if (it.req_type == REQ_SAMPLE && sb.reads_unwritten())
            it = random_load(sb.next_cp, int'($urandom));
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_request(it);
        phase_sent++;
    endtask

    // Holds the input quiet until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // The write enable drops for a cycle after each write, so two writes in a
    // row never drive it twice at the same edge.
    task automatic write_reg(input logic idx, input logic [STEP_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_cfg(idx, val);
        @(posedge clk);
    endtask

    // Hand-picked items against a four-point envelope, with entry 3 placed
    // before entry 2 in time so that one interpolation extrapolates.
    task automatic directed_part();
        send(make_load(0, 0, -100, 100));
        send(make_load(1, 100, -32768, 32767));
        send(make_load(2, 150, 0, 0));
        send(make_load(3, 100, 32767, 32767));
        // A sample and an end while no test runs change nothing.
        send(make_sample(5, 1, 2, 3));
        send(make_end(1'b1));
        send(make_begin());
        // Early sample at the most negative time only becomes the start point.
        send(make_sample(32'h8000_0000, -32768, -32768, -32768));
        // Full-scale swing across the whole time range lands at +32767: fails.
        send(make_sample(0, 32767, 32767, 32767));
        send(make_sample(150, 0, 0, 0));
        // Same time as the previous sample: the current value is used as is.
        send(make_sample(150, 0, 0, 0));
        // Time runs backwards, so the interpolation overshoots and saturates.
        send(make_sample(120, 30000, 30000, 30000));
        // Every checkpoint is done, so this sample is ignored.
        send(make_sample(500, -5, -5, -5));
        send(make_end(1'b1));
        send(make_end(1'b1));
        // An incomplete end, then a completed end with checkpoints left.
        send(make_begin());
        send(make_end(1'b0));
        send(make_begin());
        send(make_end(1'b1));
        // Three failures in a row end the test on the spot.
        send(make_load(1, 100, 1, 1));
        send(make_begin());
        send(make_sample(0, 1000, 1000, 1000));
        send(make_sample(100, 1000, 1000, 1000));
        send(make_sample(150, 1000, 1000, 1000));
        send(make_sample(200, 0, 0, 0));
    endtask

    // One well-formed test: fill in the envelope where needed, begin, walk
    // the checkpoints with samples, then end it.
    task automatic envelope_test();
        int cnt;
        int spacing;
        int base;
        int tries;
        bit reload;
        cnt     = sb.active_count();
        spacing = $urandom_range(1, 400);
        base    = ($urandom_range(7) == 0) ? int'($urandom)
                                           : int'($urandom_range(0, 4000)) - 2000;
        reload  = ($urandom_range(3) == 0);
        for (int k = 0; k < cnt; k++) begin
            if (reload || !sb.written[k])
                send(random_load(k, base + k * spacing + int'($urandom_range(0, spacing / 2))));
        end
        send(make_begin());
        tries = 0;
        while (sb.status == TS_TESTING && sb.next_cp < cnt && tries < 3 * cnt + 4) begin
            send(random_sample(spacing));
            tries++;
            // Now and then the test is abandoned part way through.
            if ($urandom_range(40) == 0) break;
        end
        repeat ($urandom_range(0, 2)) send(random_sample(spacing));
        send(make_end($urandom_range(7) != 0));
    endtask

    task automatic random_part(input int target);
        phase_sent = 0;
        while (phase_sent < target) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 4)) send(rand_item());
            end else begin
                envelope_test();
            end
        end
    endtask

    initial begin
        logic [STEP_BITS-1:0] steps [9];
        int counts [9];

        steps  = '{31'd1, 31'h7FFF_FFFF, 31'd1000000, 31'd25, 31'd100000,
                   31'd7, 31'd0, 31'd300, 31'h7FFF_FFFF};
        counts = '{3, 64, 1, 2, 127, 0, 5, 100, 16};
        steps[6] = 31'($urandom_range(1, 32'h7FFF_FFFF));

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_STEP_TIME;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        write_reg(CFG_STEP_TIME, 31'd1000);
        write_reg(CFG_POINT_COUNT, 31'd4);
        directed_part();
        drain();

        // Three idling modes: mostly stalled receiver, then mostly idle
        // sender, then full speed on both sides. Each mode runs three
        // register settings.
        for (int p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(CFG_STEP_TIME, steps[p]);
            write_reg(CFG_POINT_COUNT, STEP_BITS'(counts[p]));
            // Long receiver hold-off while items keep coming.
            if (p == 2 || p == 8) hold_req = 1'b1;
            random_part(140);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/mem_pkg.sv
src/mem_ram.sv
src/motion_envelope_matcher_top.sv
sim/tb_motion_envelope_matcher_top.sv
